[hdl/pls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// shared types and constants of the positional list store
// ----------------------------------------------------------------------------
package pls_pkg;

	localparam int OPCODE_W   = 3;
	localparam int POSITION_W = 5;
	localparam int VALUE_W    = 32;
	localparam int FOUND_W    = 5;
	localparam int COUNT_W    = 5;

	// stream payload widths, padded to whole bytes
	localparam int IN_BITS    = OPCODE_W + POSITION_W + VALUE_W;
	localparam int OUT_BITS   = 1 + VALUE_W + FOUND_W + COUNT_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OPCODE_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_READ   = 3'd3,
		OP_SEARCH = 3'd4
	} pls_op_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic               append_en;
		logic               insert_en;
		logic               delete_en;
		logic               read_en;
		logic               search_en;
		logic [VALUE_W-1:0] value;
	} pls_ctl_t;

endpackage

[hdl/pls_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_cell
// one list slot: holds, shifts from a neighbor, loads or compares
// ----------------------------------------------------------------------------
module pls_cell import pls_pkg::*; #(
	parameter int INDEX = 0,
	parameter int IW    = 4,
	parameter int CW    = 5
) (
	input  logic               clk,
	input  pls_ctl_t           ctl,
	input  logic [IW-1:0]      k,
	input  logic [CW-1:0]      count,
	input  logic [VALUE_W-1:0] left_data,
	input  logic [VALUE_W-1:0] right_data,
	output logic [VALUE_W-1:0] data,
	output logic               hit
);

	localparam logic [IW-1:0] IDX  = IW'(INDEX);
	localparam logic [CW-1:0] IDXC = CW'(INDEX);

	logic [VALUE_W-1:0] data_q;
	logic [VALUE_W-1:0] data_nxt;

	always_comb begin
		data_nxt = data_q;
		if (ctl.append_en && count == IDXC) begin
			data_nxt = ctl.value;
		end
		if (ctl.insert_en) begin
			if (k == IDX) begin
				data_nxt = ctl.value;
			end else if (IDX > k) begin
				data_nxt = left_data;
			end
		end
		// close the gap: everything from the deleted slot up moves down
		if (ctl.delete_en && IDX >= k) begin
			data_nxt = right_data;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;
	assign hit  = (ctl.read_en && k == IDX) ||
	              (ctl.search_en && IDXC < count && data_q == ctl.value);

endmodule

[hdl/pls_tree.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_tree
// registered leftmost-hit reduction over the cell flags
// ----------------------------------------------------------------------------
module pls_tree import pls_pkg::*; #(
	parameter int LEVELS = 4,
	localparam int LEAVES = 1 << LEVELS
) (
	input  logic                           clk,
	input  logic [LEAVES-1:0]              leaf_hit,
	input  logic [LEAVES-1:0][VALUE_W-1:0] leaf_data,
	output logic                           root_hit,
	output logic [LEVELS-1:0]              root_idx,
	output logic [VALUE_W-1:0]             root_data
);

	// heap layout: node 1 is the root, leaves sit at LEAVES..2*LEAVES-1
	logic               hit_q  [1:2*LEAVES-1];
	logic [LEVELS-1:0]  idx_q  [1:2*LEAVES-1];
	logic [VALUE_W-1:0] data_q [1:2*LEAVES-1];

	always_ff @(posedge clk) begin
		for (int n = 0; n < LEAVES; n++) begin
			hit_q[LEAVES+n]  <= leaf_hit[n];
			idx_q[LEAVES+n]  <= LEVELS'(n);
			data_q[LEAVES+n] <= leaf_data[n];
		end
		// one tree level per cycle, left child wins
		for (int n = 1; n < LEAVES; n++) begin
			hit_q[n] <= hit_q[2*n] | hit_q[2*n+1];
			if (hit_q[2*n]) begin
				idx_q[n]  <= idx_q[2*n];
				data_q[n] <= data_q[2*n];
			end else begin
				idx_q[n]  <= idx_q[2*n+1];
				data_q[n] <= data_q[2*n+1];
			end
		end
	end

	assign root_hit  = hit_q[1];
	assign root_idx  = idx_q[1];
	assign root_data = data_q[1];

endmodule

[hdl/positional_list_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store
// ordered list of signed 32-bit values with append, insert, delete, read
// and search by 1-based position
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one value per cell; insert and
// delete shift the cells above the position by one place, all together.
// One request is worked on at a time. Append, insert, delete and unused
// opcodes go from input transfer to the next input transfer through accept,
// cell update and result hand-off. For read and search the cell flags go
// through a registered leftmost-hit tree of $clog2(CAPACITY) levels before
// the result is known. A finished result waits in the output register, so
// the next request is taken while the previous result is still unclaimed.
// There is no clearing pass after reset: only the element count, the
// sequencer state and the output valid are reset, and cells at or above the
// count are never read. Failed requests leave the list unchanged and return
// ok low; a failed read returns -1. Every result carries the element count
// after the request, truncated to the 5-bit field.
// ----------------------------------------------------------------------------
module positional_list_store import pls_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // opcode[2:0], position[7:3], value[39:8]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // ok[0], read_value[32:1],
	                                        // found_position[37:33], count[42:38]
);

	localparam int LEVELS = $clog2(CAPACITY);
	localparam int LEAVES = 1 << LEVELS;
	localparam int IW     = LEVELS;
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int CMPW   = ((CW > POSITION_W) ? CW : POSITION_W) + 1;
	localparam int TCW    = $clog2(LEVELS + 1);

	localparam logic [CMPW-1:0] CAP_C    = CMPW'(CAPACITY);
	localparam logic [TCW-1:0]  TREE_END = TCW'(LEVELS - 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_TREE   = 5'b00100,
		ST_RESULT = 5'b01000,
		ST_PEND   = 5'b10000
	} state_t;

	state_t state_q;

	// request fields
	logic [OPCODE_W-1:0]   in_opcode;
	logic [POSITION_W-1:0] in_position;
	logic [VALUE_W-1:0]    in_value;

	assign in_opcode   = s_tdata[OPCODE_W-1:0];
	assign in_position = s_tdata[OPCODE_W+POSITION_W-1:OPCODE_W];
	assign in_value    = s_tdata[IN_BITS-1:OPCODE_W+POSITION_W];

	// held request
	logic               is_append_q, is_insert_q, is_delete_q, is_read_q, is_search_q;
	logic               req_ok_q;
	logic [IW-1:0]      k_q;
	logic [VALUE_W-1:0] value_q;
	logic [CW-1:0]      count_q;
	logic [TCW-1:0]     tree_cnt_q;

	// held result
	logic               res_ok_q;
	logic [VALUE_W-1:0] res_rd_q;
	logic [FOUND_W-1:0] res_found_q;
	logic [COUNT_W-1:0] res_count_q;

	// output register
	logic               out_valid_q;
	logic [OUT_BITS-1:0] out_q;

	// range checks on the incoming request
	logic [CMPW-1:0] pos_ext, cnt_ext;
	logic            not_full, pos_in_list, pos_insertable;
	logic            in_take;

	assign pos_ext        = CMPW'(in_position);
	assign cnt_ext        = CMPW'(count_q);
	assign not_full       = cnt_ext < CAP_C;
	assign pos_in_list    = (in_position != '0) && (pos_ext <= cnt_ext);
	assign pos_insertable = (in_position != '0) && (pos_ext <= cnt_ext + CMPW'(1));
	assign in_take        = s_tvalid && s_tready;

	assign s_tready = (state_q == ST_IDLE);

	// cell row
	pls_ctl_t                         ctl;
	logic [CAPACITY-1:0][VALUE_W-1:0] cell_data;
	logic [LEAVES-1:0]                leaf_hit;
	logic [LEAVES-1:0][VALUE_W-1:0]   leaf_data;
	logic                             exec;

	assign exec          = (state_q == ST_EXEC);
	assign ctl.append_en = exec && is_append_q && req_ok_q;
	assign ctl.insert_en = exec && is_insert_q && req_ok_q;
	assign ctl.delete_en = exec && is_delete_q && req_ok_q;
	assign ctl.read_en   = exec && is_read_q && req_ok_q;
	assign ctl.search_en = exec && is_search_q;
	assign ctl.value     = value_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_W-1:0] left_d, right_d;
		if (i == 0) begin : g_first
			assign left_d = cell_data[i];
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end
		pls_cell #(
			.INDEX (i),
			.IW    (IW),
			.CW    (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.k          (k_q),
			.count      (count_q),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.hit        (leaf_hit[i])
		);
		assign leaf_data[i] = cell_data[i];
	end

	// spare leaves of the tree never hit
	for (genvar j = CAPACITY; j < LEAVES; j++) begin : g_pad
		assign leaf_hit[j]  = 1'b0;
		assign leaf_data[j] = '0;
	end

	logic               root_hit;
	logic [IW-1:0]      root_idx;
	logic [VALUE_W-1:0] root_data;

	pls_tree #(
		.LEVELS (LEVELS)
	) u_tree (
		.clk       (clk),
		.leaf_hit  (leaf_hit),
		.leaf_data (leaf_data),
		.root_hit  (root_hit),
		.root_idx  (root_idx),
		.root_data (root_data)
	);

	// request capture, payload only
	always_ff @(posedge clk) begin
		if (in_take) begin
			is_append_q <= 1'b0;
			is_insert_q <= 1'b0;
			is_delete_q <= 1'b0;
			is_read_q   <= 1'b0;
			is_search_q <= 1'b0;
			req_ok_q    <= 1'b0;
			unique case (pls_op_t'(in_opcode))
				OP_APPEND: begin
					is_append_q <= 1'b1;
					req_ok_q    <= not_full;
				end
				OP_INSERT: begin
					is_insert_q <= 1'b1;
					req_ok_q    <= not_full && pos_insertable;
				end
				OP_DELETE: begin
					is_delete_q <= 1'b1;
					req_ok_q    <= pos_in_list;
				end
				OP_READ: begin
					is_read_q <= 1'b1;
					req_ok_q  <= pos_in_list;
				end
				OP_SEARCH: begin
					is_search_q <= 1'b1;
				end
				default: begin
				end
			endcase
			k_q     <= IW'(pos_ext - CMPW'(1));
			value_q <= in_value;
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		if (exec) begin
			res_ok_q    <= req_ok_q;
			res_rd_q    <= '0;
			res_found_q <= '0;
			if ((is_append_q || is_insert_q) && req_ok_q) begin
				res_count_q <= COUNT_W'(count_q + CW'(1));
			end else if (is_delete_q && req_ok_q) begin
				res_count_q <= COUNT_W'(count_q - CW'(1));
			end else begin
				res_count_q <= COUNT_W'(count_q);
			end
		end else if (state_q == ST_RESULT) begin
			res_ok_q <= root_hit;
			if (is_read_q) begin
				res_rd_q    <= root_hit ? root_data : '1;
				res_found_q <= '0;
			end else begin
				res_rd_q    <= '0;
				res_found_q <= root_hit ? FOUND_W'((IW + 1)'(root_idx) + (IW + 1)'(1)) : '0;
			end
		end
	end

	// sequencer and element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			tree_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					tree_cnt_q <= '0;
					if (is_read_q || is_search_q) begin
						state_q <= ST_TREE;
					end else begin
						state_q <= ST_PEND;
					end
					if ((is_append_q || is_insert_q) && req_ok_q) begin
						count_q <= count_q + CW'(1);
					end else if (is_delete_q && req_ok_q) begin
						count_q <= count_q - CW'(1);
					end
				end
				ST_TREE: begin
					// wait for the flags to reach the root
					if (tree_cnt_q == TREE_END) begin
						state_q <= ST_RESULT;
					end else begin
						tree_cnt_q <= tree_cnt_q + TCW'(1);
					end
				end
				ST_RESULT: begin
					state_q <= ST_PEND;
				end
				ST_PEND: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	logic out_load;
	assign out_load = (state_q == ST_PEND) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= {res_count_q, res_found_q, res_rd_q, res_ok_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(out_q);

endmodule

[hdl/pls_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_checker
// port-level checks on the positional list store
// ----------------------------------------------------------------------------
module pls_checker import pls_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	logic                 r_ok;
	logic [FOUND_W-1:0]   r_found;
	logic [COUNT_W-1:0]   r_count;

	assign r_ok    = m_tdata[0];
	assign r_found = m_tdata[1+VALUE_W+FOUND_W-1:1+VALUE_W];
	assign r_count = m_tdata[OUT_BITS-1:1+VALUE_W+FOUND_W];

	// a result waiting for the sink stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// one request at a time: no transfer in the cycle after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// a found position only comes with ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r_found != '0 |-> r_ok)
		else $error("found position without ok");

	// the count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && CAPACITY < 32 |-> 32'(r_count) <= 32'(CAPACITY))
		else $error("count above capacity");

endmodule

bind positional_list_store pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (.*);
